### hw/rtl/mode_frequency_tracker_core_assert.svh
// Assertion macros used by the tracker's core RTL.
`ifndef MODE_FREQUENCY_TRACKER_CORE_ASSERT_SVH
`define MODE_FREQUENCY_TRACKER_CORE_ASSERT_SVH

// Implication that must hold in the same cycle.
`define MFT_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Implication whose consequent must hold in the next cycle.
`define MFT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hw/rtl/mft_pkg.sv
package mft_pkg;

    localparam int VALUE_W = 64;
    localparam int COUNT_W = 32;

    localparam logic FUNC_ADD   = 1'b0;
    localparam logic FUNC_CLEAR = 1'b1;

    typedef struct packed {
        logic                      func;
        logic signed [VALUE_W-1:0] value;
        logic [COUNT_W-1:0]        inc;
    } t_item;

    typedef struct packed {
        logic               hit;
        logic [COUNT_W-1:0] count;
        logic               dropped;
        logic               saturated;
    } t_upd;

endpackage

### hw/rtl/mft_tbl.sv
module mft_tbl #(
    parameter int DEPTH = 64
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_vld,
    input  mft_pkg::t_item i_item,
    output mft_pkg::t_upd  o_upd
);
    import mft_pkg::*;

    localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int USED_W = $clog2(DEPTH + 1);

    logic signed [VALUE_W-1:0] r_values [DEPTH];
    logic [COUNT_W-1:0]        r_counts [DEPTH];
    logic [DEPTH-1:0]          r_valid;
    logic [USED_W-1:0]         r_used;

    logic [DEPTH-1:0]   s_match;
    logic [COUNT_W-1:0] s_sel;
    logic               s_any;
    logic               s_free;
    logic               s_add;
    logic               s_clr;
    logic               s_alloc;
    logic [IDX_W-1:0]   s_slot;
    logic [COUNT_W:0]   s_sum;
    logic               s_sat;
    logic [COUNT_W-1:0] s_new;

    // Valid values are unique, so at most one match bit is set and the
    // AND-OR select below picks exactly that entry's count.
    always_comb begin
        s_sel = '0;
        for (int i = 0; i < DEPTH; i++) begin
            s_match[i] = r_valid[i] && (r_values[i] == i_item.value);
            if (s_match[i]) begin
                s_sel = s_sel | r_counts[i];
            end
        end
    end

    assign s_any   = |s_match;
    assign s_free  = r_used < USED_W'(DEPTH);
    assign s_add   = i_vld && (i_item.func == FUNC_ADD) && (i_item.inc != '0);
    assign s_clr   = i_vld && (i_item.func == FUNC_CLEAR);
    assign s_alloc = s_add && !s_any && s_free;
    assign s_slot  = r_used[IDX_W-1:0];
    assign s_sum   = {1'b0, (s_any ? s_sel : {COUNT_W{1'b0}})} + {1'b0, i_item.inc};
    assign s_sat   = s_sum[COUNT_W];
    assign s_new   = s_sat ? {COUNT_W{1'b1}} : s_sum[COUNT_W-1:0];

    always_comb begin
        o_upd.hit       = s_add && (s_any || s_free);
        o_upd.count     = s_new;
        o_upd.dropped   = s_add && !s_any && !s_free;
        o_upd.saturated = s_add && (s_any || s_free) && s_sat;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_used  <= '0;
        end else if (s_clr) begin
            r_valid <= '0;
            r_used  <= '0;
        end else if (s_alloc) begin
            r_valid[s_slot] <= 1'b1;
            r_used          <= r_used + USED_W'(1);
        end
    end

    // Entries fill in index order, so the fill count is also the free slot.
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < DEPTH; i++) begin
            if (s_add && s_match[i]) begin
                r_counts[i] <= s_new;
            end else if (s_alloc && (s_slot == IDX_W'(i))) begin
                r_values[i] <= i_item.value;
                r_counts[i] <= s_new;
            end
        end
    end

endmodule

### hw/rtl/mft_mode.sv
module mft_mode (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_clr,
    input  logic signed [mft_pkg::VALUE_W-1:0] i_value,
    input  mft_pkg::t_upd                      i_upd,
    output logic signed [mft_pkg::VALUE_W-1:0] o_best_value,
    output logic [mft_pkg::COUNT_W-1:0]        o_best_count
);
    import mft_pkg::*;

    logic signed [VALUE_W-1:0] r_value;
    logic signed [VALUE_W-1:0] n_value;
    logic [COUNT_W-1:0]        r_count;
    logic [COUNT_W-1:0]        n_count;

    // Counts only grow, so offering each updated entry keeps the mode exact.
    always_comb begin
        n_value = r_value;
        n_count = r_count;
        if (i_clr) begin
            n_value = '0;
            n_count = '0;
        end else if (i_upd.hit && ((i_upd.count > r_count) ||
                     ((i_upd.count == r_count) && (i_value < r_value)))) begin
            n_value = i_value;
            n_count = i_upd.count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_value <= '0;
            r_count <= '0;
        end else begin
            r_value <= n_value;
            r_count <= n_count;
        end
    end

    assign o_best_value = n_value;
    assign o_best_count = n_count;

endmodule

### hw/rtl/mode_frequency_tracker_core.sv
// A beat accepted at a clock edge passes through the input register, then the result
// register, which raises its result strobe.
// Throughput: one beat per cycle; busy never rises, the table match and count add
// complete combinationally between the input register and the result register.
// Reset (synchronous, active low) empties the table, forgets the mode and drops strobes.
// The receiver cannot stall: each result is shown for exactly one cycle.
module mode_frequency_tracker_core #(
    parameter int TABLE_DEPTH = 64
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic                               i_func,
    input  logic signed [mft_pkg::VALUE_W-1:0] i_item_value,
    input  logic [mft_pkg::COUNT_W-1:0]        i_increment,
    output logic                               o_strobe,
    output logic                               o_mode_valid,
    output logic signed [mft_pkg::VALUE_W-1:0] o_mode_value,
    output logic [mft_pkg::COUNT_W-1:0]        o_mode_count,
    output logic                               o_dropped,
    output logic                               o_saturated
);
    import mft_pkg::*;

    `include "mode_frequency_tracker_core_assert.svh"

    logic                      r_req_vld;
    t_item                     r_req;
    logic                      s_req_clr;
    t_upd                      s_upd;
    logic signed [VALUE_W-1:0] s_best_value;
    logic [COUNT_W-1:0]        s_best_count;

    logic                      r_strobe;
    logic                      r_mode_valid;
    logic signed [VALUE_W-1:0] r_mode_value;
    logic [COUNT_W-1:0]        r_mode_count;
    logic                      r_dropped;
    logic                      r_saturated;

    assign busy = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_req_vld <= 1'b0;
        end else begin
            r_req_vld <= start && !busy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (start && !busy) begin
            r_req.func  <= i_func;
            r_req.value <= i_item_value;
            r_req.inc   <= i_increment;
        end
    end

    assign s_req_clr = r_req_vld && (r_req.func == FUNC_CLEAR);

    mft_tbl #(
        .DEPTH (TABLE_DEPTH)
    ) u_tbl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (r_req_vld),
        .i_item  (r_req),
        .o_upd   (s_upd)
    );

    mft_mode u_mode (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_clr        (s_req_clr),
        .i_value      (r_req.value),
        .i_upd        (s_upd),
        .o_best_value (s_best_value),
        .o_best_count (s_best_count)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= r_req_vld;
        end
    end

    // The best value is zero whenever the best count is zero.
    always_ff @(posedge i_clk) begin
        r_mode_valid <= s_best_count != '0;
        r_mode_value <= s_best_value;
        r_mode_count <= s_best_count;
        r_dropped    <= s_upd.dropped;
        r_saturated  <= s_upd.saturated;
    end

    assign o_strobe     = r_strobe;
    assign o_mode_valid = r_mode_valid;
    assign o_mode_value = r_mode_value;
    assign o_mode_count = r_mode_count;
    assign o_dropped    = r_dropped;
    assign o_saturated  = r_saturated;

    `MFT_ASSERT_NEXT(a_result_follows, r_req_vld, o_strobe, "result beat missing")
    `MFT_ASSERT_NEXT(a_clear_no_mode, s_req_clr, !o_mode_valid && !o_dropped, "clear left a mode")
    `MFT_ASSERT_NOW(a_drop_or_sat, o_strobe, !(o_dropped && o_saturated), "drop with clip")
    `MFT_ASSERT_NOW(a_drop_full, o_strobe && o_dropped, o_mode_valid, "drop with empty table")

endmodule
